@@ hw/rtl/ascii_decimal_to_fixed_parser_defines.svh @@
// Assertion macros shared by the ASCII decimal parser modules.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef ASCII_DECIMAL_TO_FIXED_PARSER_DEFINES_SVH
`define ASCII_DECIMAL_TO_FIXED_PARSER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define ADFP_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ADFP_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ADFP_CHECK(lbl, prop, msg)
`define ADFP_CHECK_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ hw/rtl/adfp_pkg.sv @@
// Package of the ASCII decimal parser: parse phases, scaling states,
// character codes and default parameters. Depends on nothing.
package adfp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int MANT_BITS_DEF = 60;
  localparam int EXP_LIMIT_DEF = 40;
  localparam int QUEUE_DEPTH = 2;

  localparam int VALUE_W = 48;
  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_E_LO  = 8'h65;
  localparam logic [7:0] CH_E_UP  = 8'h45;

  typedef enum logic [2:0] {
    PH_INT   = 3'd0,
    PH_FRAC  = 3'd1,
    PH_ESIGN = 3'd2,
    PH_EDIG  = 3'd3,
    PH_STOP  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    BK_IDLE = 3'd0,
    BK_MUL  = 3'd1,
    BK_POW  = 3'd2,
    BK_DIV  = 3'd3,
    BK_OUT  = 3'd4
  } back_state_t;

endpackage

@@ hw/rtl/adfp_front.sv @@
// Character front end: parses one character per item and, on the last one,
// hands the mantissa and clamped net exponent to the job queue. Uses adfp_pkg.
module adfp_front
  import adfp_pkg::*;
#(
  parameter int MANT_BITS = MANT_BITS_DEF,
  parameter int EXP_LIMIT = EXP_LIMIT_DEF,
  localparam int MAGW = $clog2(EXP_LIMIT + 1),
  localparam int EW = MANT_BITS + MAGW + 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,
  input  logic          s_tlast,
  output logic          q_push,
  input  logic          q_ready,
  output logic [EW-1:0] q_data
);

  phase_t                 phase, phase_next;
  logic [MANT_BITS-1:0]   mant, mant_next;
  logic [7:0]             scale, scale_next;
  logic                   eneg, eneg_next;
  logic [7:0]             edig, edig_next;
  logic                   ovf, ovf_next;

  logic                   is_dig;
  logic [3:0]             dval;
  logic [MANT_BITS+3:0]   mant_t;
  logic [11:0]            exp_t;
  logic                   take_m, take_e;
  logic signed [9:0]      net;
  logic                   net_neg, net_sat;
  logic [MAGW-1:0]        net_mag;
  logic signed [9:0]      lim_pos, lim_neg;
  logic                   accept;

  assign accept = s_tvalid && s_tready;
  assign s_tready = q_ready;
  assign q_push = accept && s_tlast;

  assign is_dig = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
  assign dval = is_dig ? 4'(s_tdata - CH_ZERO) : 4'd0;
  assign mant_t = ({1'b0, mant, 3'b000} + {3'b000, mant, 1'b0}) + (MANT_BITS+4)'(dval);
  assign exp_t = ({1'b0, edig, 3'b000} + {3'b000, edig, 1'b0}) + 12'(dval);

  always_comb begin
    phase_next = phase;
    if (s_tdata == CH_NUL) begin
      phase_next = PH_STOP;
    end else begin
      case (phase)
        PH_INT: begin
          if (is_dig) phase_next = PH_INT;
          else if (s_tdata == CH_DOT) phase_next = PH_FRAC;
          else if (s_tdata == CH_E_LO || s_tdata == CH_E_UP) phase_next = PH_ESIGN;
          else phase_next = PH_STOP;
        end
        PH_FRAC: begin
          if (is_dig) phase_next = PH_FRAC;
          else if (s_tdata == CH_E_LO || s_tdata == CH_E_UP) phase_next = PH_ESIGN;
          else phase_next = PH_STOP;
        end
        PH_ESIGN: begin
          if (is_dig || s_tdata == CH_PLUS || s_tdata == CH_MINUS) phase_next = PH_EDIG;
          else phase_next = PH_STOP;
        end
        PH_EDIG: begin
          if (!is_dig) phase_next = PH_STOP;
        end
        default: phase_next = PH_STOP;
      endcase
    end
  end

  always_comb begin
    take_m = 1'b0;
    take_e = 1'b0;
    mant_next = mant;
    scale_next = scale;
    eneg_next = eneg;
    edig_next = edig;
    ovf_next = ovf;
    if (s_tdata != CH_NUL) begin
      case (phase)
        PH_INT: take_m = is_dig;
        PH_FRAC: begin
          take_m = is_dig;
          if (is_dig) begin
            if (scale == 8'hFF) ovf_next = 1'b1;
            else scale_next = scale + 8'd1;
          end
        end
        PH_ESIGN: begin
          if (s_tdata == CH_MINUS) eneg_next = 1'b1;
          take_e = is_dig;
        end
        PH_EDIG: take_e = is_dig;
        default: ;
      endcase
    end
    if (take_m) begin
      if (mant_t[MANT_BITS+3:MANT_BITS] != 4'd0) begin
        mant_next = '1;
        ovf_next = 1'b1;
      end else begin
        mant_next = mant_t[MANT_BITS-1:0];
      end
    end
    if (take_e) begin
      if (exp_t > 12'd255) begin
        edig_next = 8'hFF;
        ovf_next = 1'b1;
      end else begin
        edig_next = exp_t[7:0];
      end
    end
  end

  assign lim_pos = 10'(EXP_LIMIT);
  assign lim_neg = -10'(EXP_LIMIT);

  always_comb begin
    net = (eneg_next ? -$signed({2'b00, edig_next}) : $signed({2'b00, edig_next}))
          - $signed({2'b00, scale_next});
    net_sat = 1'b0;
    net_neg = net[9];
    net_mag = MAGW'(net_neg ? -net : net);
    if (net > lim_pos) begin
      net_sat = 1'b1;
      net_neg = 1'b0;
      net_mag = MAGW'(EXP_LIMIT);
    end else if (net < lim_neg) begin
      net_sat = 1'b1;
      net_neg = 1'b1;
      net_mag = MAGW'(EXP_LIMIT);
    end
  end

  assign q_data = {ovf_next || net_sat, net_neg, net_mag, mant_next};

  always_ff @(posedge clk) begin
    if (rst || (accept && s_tlast)) begin
      phase <= PH_INT;
      mant <= '0;
      scale <= '0;
      eneg <= 1'b0;
      edig <= '0;
      ovf <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      mant <= mant_next;
      scale <= scale_next;
      eneg <= eneg_next;
      edig <= edig_next;
      ovf <= ovf_next;
    end
  end

endmodule

@@ hw/rtl/adfp_queue.sv @@
// Short job queue between the parser front end and the scaling unit.
// Uses adfp_pkg and the assertion macros.
`include "ascii_decimal_to_fixed_parser_defines.svh"
module adfp_queue
  import adfp_pkg::*;
#(
  parameter int WIDTH = 8,
  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             ready,
  input  logic [WIDTH-1:0] wdata,
  output logic             valid,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] entry [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;

  assign ready = (count != CW'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign rdata = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop) rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (push && !pop) count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

  `ADFP_CHECK(a_count_bound, count <= CW'(QUEUE_DEPTH), "queue count beyond depth")
  `ADFP_CHECK_NEXT(a_count_up, push && !pop, count == $past(count) + CW'(1), "push lost")
  `ADFP_CHECK_NEXT(a_count_hold, push && pop, count == $past(count), "push/pop mismatch")

endmodule

@@ hw/rtl/adfp_back.sv @@
// Scaling unit: multiplies the mantissa by ten per cycle, or builds a power
// of ten and divides by it one quotient bit per cycle. Uses adfp_pkg and macros.
`include "ascii_decimal_to_fixed_parser_defines.svh"
module adfp_back
  import adfp_pkg::*;
#(
  parameter int MANT_BITS = MANT_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int EXP_LIMIT = EXP_LIMIT_DEF,
  localparam int MAGW = $clog2(EXP_LIMIT + 1),
  localparam int EW = MANT_BITS + MAGW + 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_pop,
  input  logic [EW-1:0]      q_data,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [VALUE_W-1:0] m_tdata,
  output logic               m_tuser
);

  localparam int NW = MANT_BITS + FRAC_BITS;
  localparam int XW = ((MANT_BITS > VALUE_W) ? MANT_BITS : VALUE_W) + 4;
  localparam int DW = (EXP_LIMIT * 3322) / 1000 + 2;
  localparam int BCW = $clog2(NW + 1);
  localparam logic [XW-1:0] VMAX_X = XW'(VALUE_MAX);
  localparam logic [XW-1:0] LIM_X = XW'(VALUE_MAX >> FRAC_BITS);

  back_state_t state, state_next;

  logic [MANT_BITS-1:0] e_mant;
  logic [MAGW-1:0]      e_mag;
  logic                 e_neg, e_sat;

  logic [XW-1:0]        x;
  logic [MAGW-1:0]      cnt;
  logic [DW-1:0]        pow, rem;
  logic [NW-1:0]        nsh, quo;
  logic [BCW-1:0]       bits;
  logic [VALUE_W-1:0]   res;
  logic                 rsat;

  logic [XW+3:0]        x10;
  logic                 x10_big;
  logic [DW-1:0]        pow10;
  logic [DW:0]          r2, rsub;
  logic                 ge;
  logic [NW+VALUE_W-1:0] qext;
  logic                 load_out;

  assign {e_sat, e_neg, e_mag, e_mant} = q_data;

  assign x10 = {1'b0, x, 3'b000} + {3'b000, x, 1'b0};
  assign x10_big = x10 > (XW+4)'(VALUE_MAX);
  assign pow10 = DW'({pow, 3'b000}) + DW'({pow, 1'b0});
  assign r2 = {rem, nsh[NW-1]};
  assign rsub = r2 - {1'b0, pow};
  assign ge = r2 >= {1'b0, pow};
  assign qext = {{VALUE_W{1'b0}}, quo};

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          if (e_mant == '0) state_next = BK_OUT;
          else if (!e_neg) state_next = (XW'(e_mant) > VMAX_X) ? BK_OUT : BK_MUL;
          else state_next = BK_POW;
        end
      end
      BK_MUL: if (cnt == '0 || x10_big) state_next = BK_OUT;
      BK_POW: if (cnt == '0) state_next = BK_DIV;
      BK_DIV: if (bits == '0) state_next = BK_OUT;
      BK_OUT: if (load_out) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state == BK_IDLE) && q_valid;
    load_out = (state == BK_OUT) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          rsat <= e_sat;
          x <= XW'(e_mant);
          cnt <= e_mag;
          pow <= DW'(1);
          nsh <= NW'(e_mant) << FRAC_BITS;
          res <= '0;
          if (e_mant != '0 && !e_neg && XW'(e_mant) > VMAX_X) begin
            res <= VALUE_MAX;
            rsat <= 1'b1;
          end
        end
      end
      BK_MUL: begin
        if (cnt == '0) begin
          if (x > LIM_X) begin
            res <= VALUE_MAX;
            rsat <= 1'b1;
          end else begin
            res <= VALUE_W'(x) << FRAC_BITS;
          end
        end else if (x10_big) begin
          res <= VALUE_MAX;
          rsat <= 1'b1;
        end else begin
          x <= x10[XW-1:0];
          cnt <= cnt - MAGW'(1);
        end
      end
      BK_POW: begin
        if (cnt == '0) begin
          rem <= '0;
          bits <= BCW'(NW);
        end else begin
          pow <= pow10;
          cnt <= cnt - MAGW'(1);
        end
      end
      BK_DIV: begin
        if (bits == '0) begin
          if (qext[NW+VALUE_W-1:VALUE_W] != '0) begin
            res <= VALUE_MAX;
            rsat <= 1'b1;
          end else begin
            res <= qext[VALUE_W-1:0];
          end
        end else begin
          rem <= ge ? rsub[DW-1:0] : r2[DW-1:0];
          quo <= {quo[NW-2:0], ge};
          nsh <= nsh << 1;
          bits <= bits - BCW'(1);
        end
      end
      BK_OUT: begin
        if (load_out) begin
          m_tdata <= res;
          m_tuser <= rsat;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (load_out) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  `ADFP_CHECK(a_mul_range, (state == BK_MUL) |-> (x <= VMAX_X), "multiplier operand too large")
  `ADFP_CHECK(a_div_nonzero, (state == BK_DIV) |-> (pow != '0), "divisor is zero")
  `ADFP_CHECK_NEXT(a_out_load, load_out, m_tvalid && m_tdata == $past(res), "result not loaded")

endmodule

@@ hw/rtl/ascii_decimal_to_fixed_parser.sv @@
// ASCII decimal number parser producing unsigned fixed point with FRAC_BITS
// fraction bits. Depends on adfp_pkg, adfp_front, adfp_queue and adfp_back.
//
// Characters are taken one item per cycle while the job queue has room; a
// string ends with tlast on its final character. The scaling unit then
// works on the parsed job: a positive net exponent e is applied by one
// multiply by ten per cycle, a negative exponent of size k by building ten
// to the k one step per cycle and a restoring divider that yields one
// quotient bit per cycle. A two-entry job queue and the output register
// let the next string be parsed while earlier ones are scaled or wait to
// be taken.
module ascii_decimal_to_fixed_parser
  import adfp_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MANT_BITS = MANT_BITS_DEF,
  parameter int EXP_LIMIT = EXP_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // character[7:0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // value[47:0]
  output logic        m_tuser    // saturated
);

  localparam int MAGW = $clog2(EXP_LIMIT + 1);
  localparam int EW = MANT_BITS + MAGW + 2;

  logic          push, push_ready, job_valid, job_pop;
  logic [EW-1:0] push_data, job_data;

  adfp_front #(
    .MANT_BITS(MANT_BITS),
    .EXP_LIMIT(EXP_LIMIT)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .q_push(push),
    .q_ready(push_ready),
    .q_data(push_data)
  );

  adfp_queue #(
    .WIDTH(EW)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .ready(push_ready),
    .wdata(push_data),
    .valid(job_valid),
    .pop(job_pop),
    .rdata(job_data)
  );

  adfp_back #(
    .MANT_BITS(MANT_BITS),
    .FRAC_BITS(FRAC_BITS),
    .EXP_LIMIT(EXP_LIMIT)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(job_valid),
    .q_pop(job_pop),
    .q_data(job_data),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

endmodule
